>>> rtl/assert_macros.svh
// Assertion helpers for the decoder checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define MRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// clocked property, checked during reset too
`define MRD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/mrd_pkg.sv
`default_nettype none
package mrd_pkg;

    localparam int MIDX_W    = 3;
    localparam int NEG_W     = 3;
    localparam int CFG_DW    = 16;
    localparam int CFG_IW    = 3;
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_CYCLE = 2'd1;
    localparam logic [1:0] OP_TRACK = 2'd2;

    localparam logic [2:0] KIND_ENC     = 3'd0;
    localparam logic [2:0] KIND_STATUS  = 3'd1;
    localparam logic [2:0] KIND_TORQUE  = 3'd2;
    localparam logic [2:0] KIND_GAINS   = 3'd3;
    localparam logic [2:0] KIND_ACK     = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;
    localparam logic [2:0] KIND_CYCLE   = 3'd6;
    localparam logic [2:0] KIND_IGNORED = 3'd7;

    localparam logic [7:0] CMD_ENC    = 8'h90;
    localparam logic [7:0] CMD_STATUS = 8'h9a;
    localparam logic [7:0] CMD_TORQUE = 8'ha1;
    localparam logic [7:0] CMD_GAINS  = 8'h30;
    localparam logic [7:0] CMD_ACK_A  = 8'h88;
    localparam logic [7:0] CMD_ACK_B  = 8'h80;
    localparam logic [7:0] CMD_ACK_C  = 8'h32;
    localparam logic [7:0] CMD_ACK_D  = 8'h19;

    localparam logic [CFG_IW-1:0] REG_ID_BASE     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_AXIS_NEGATE = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FAIL_LIMIT  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WRAP_LOW    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WRAP_HIGH   = 3'd4;

    localparam logic [10:0] RST_ID_BASE     = 11'd321;
    localparam logic [2:0]  RST_AXIS_NEGATE = 3'd6;
    localparam logic [7:0]  RST_FAIL_LIMIT  = 8'd10;
    localparam logic [15:0] RST_WRAP_LOW    = 16'd10000;
    localparam logic [15:0] RST_WRAP_HIGH   = 16'd50000;

    localparam logic [15:0] ENC_PARK  = 16'd35000;
    localparam logic [7:0]  FAIL_MAX  = 8'd255;
    localparam logic signed [15:0] TURN_MAX = 16'sh7fff;
    localparam logic signed [15:0] TURN_MIN = -16'sh8000;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
        logic        tx_failed;
    } t_in;

    typedef struct packed {
        logic [1:0]         motor;
        logic [2:0]         kind;
        logic signed [31:0] position;
        logic signed [15:0] speed;
        logic signed [15:0] torque_current;
        logic [7:0]         temperature;
        logic [15:0]        voltage;
        logic [7:0]         fault_code;
        logic [7:0]         fail_count;
        logic               diverged;
    } t_out;

    typedef struct packed {
        logic [10:0] id_base;
        logic [2:0]  axis_negate;
        logic [7:0]  fail_limit;
        logic [15:0] wrap_low;
        logic [15:0] wrap_high;
    } t_cfg;

    // classified event between front and back
    typedef struct packed {
        logic [2:0]        kind;
        logic [MIDX_W-1:0] motor;
        logic              neg;
        logic              track;
        logic              tx_failed;
        logic [15:0]       enc;
        logic [15:0]       trq;
        logic [15:0]       spd;
        logic [7:0]        temp;
        logic [15:0]       volt;
        logic [7:0]        err;
    } t_cmd;

    function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
        return (v == TURN_MIN) ? TURN_MAX : -v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mrd_fifo.sv
`default_nettype none
module mrd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mrd_front.sv
`default_nettype none
module mrd_front #(
    parameter int MOTORS = 3
) (
    input  wire mrd_pkg::t_in  i_in,
    input  wire mrd_pkg::t_cfg i_cfg,
    output mrd_pkg::t_cmd      o_cmd
);
    import mrd_pkg::*;

    logic [11:0]       diff;
    logic              in_range;
    logic [MIDX_W-1:0] m;

    assign diff     = {1'b0, i_in.frame_id} - {1'b0, i_cfg.id_base};
    assign in_range = !diff[11] && (diff[10:0] < 11'(MOTORS));
    assign m        = diff[MIDX_W-1:0];

    always_comb begin
        o_cmd           = '0;
        o_cmd.kind      = KIND_IGNORED;
        o_cmd.tx_failed = i_in.tx_failed;
        case (i_in.op)
            OP_FRAME: begin
                if (in_range) begin
                    o_cmd.motor = m;
                    o_cmd.neg   = (m < MIDX_W'(NEG_W)) ? i_cfg.axis_negate[m[1:0]] : 1'b0;
                    case (i_in.byte0)
                        CMD_ENC: begin
                            o_cmd.kind = KIND_ENC;
                            o_cmd.enc  = {i_in.byte3, i_in.byte2};
                        end
                        CMD_STATUS: begin
                            o_cmd.kind = KIND_STATUS;
                            o_cmd.temp = i_in.byte1;
                            o_cmd.volt = {i_in.byte4, i_in.byte3};
                            o_cmd.err  = i_in.byte7;
                        end
                        CMD_TORQUE: begin
                            o_cmd.kind = KIND_TORQUE;
                            o_cmd.temp = i_in.byte1;
                            o_cmd.trq  = {i_in.byte3, i_in.byte2};
                            o_cmd.spd  = {i_in.byte5, i_in.byte4};
                            o_cmd.enc  = {i_in.byte7, i_in.byte6};
                        end
                        CMD_GAINS: o_cmd.kind = KIND_GAINS;
                        CMD_ACK_A, CMD_ACK_B, CMD_ACK_C, CMD_ACK_D: o_cmd.kind = KIND_ACK;
                        default: o_cmd.kind = KIND_UNKNOWN;
                    endcase
                end
            end
            OP_CYCLE: o_cmd.kind = KIND_CYCLE;
            OP_TRACK: o_cmd.track = 1'b1;
            default: o_cmd.kind = KIND_IGNORED;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/mrd_back.sv
`default_nettype none
module mrd_back #(
    parameter int MOTORS = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mrd_pkg::t_cfg i_cfg,
    input  wire mrd_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire logic          i_res_ready,
    output logic               o_res_valid,
    output mrd_pkg::t_out      o_res
);
    import mrd_pkg::*;

    localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         motor;
        logic               neg;
        logic [15:0]        enc;
        logic signed [15:0] turns;
        logic [15:0]        trq;
        logic [15:0]        spd;
        logic [7:0]         temp;
        logic [15:0]        volt;
        logic [7:0]         err;
        logic [7:0]         fail;
        logic               div;
    } t_stage;

    logic [15:0]        r_last  [MOTORS];
    logic signed [15:0] r_turns [MOTORS];
    logic [MOTORS-1:0]  r_seen;
    logic [7:0]         r_fail;
    logic               r_div;
    logic               r_a_valid;
    t_stage             r_a;

    logic [15:0]        n_last  [MOTORS];
    logic signed [15:0] n_turns [MOTORS];
    logic [MOTORS-1:0]  n_seen;
    logic [7:0]         n_fail;
    logic               n_div;
    t_stage             n_a;

    logic               en, go, unwrap, bad, inc, dec;
    logic [MW-1:0]      mi;
    logic [15:0]        past;
    logic signed [15:0] t_cur, t_new;

    assign en        = !r_a_valid || i_res_ready;
    assign go        = en && i_cmd_valid;
    assign o_cmd_pop = go;
    assign mi        = i_cmd.motor[MW-1:0];
    assign unwrap    = (i_cmd.kind == KIND_ENC) || (i_cmd.kind == KIND_TORQUE);
    assign past      = r_last[mi];
    assign t_cur     = r_turns[mi];
    assign inc       = (i_cmd.enc < i_cfg.wrap_low) && (past > i_cfg.wrap_high);
    assign dec       = (i_cmd.enc > i_cfg.wrap_high) && (past < i_cfg.wrap_low);

    always_comb begin
        if (inc) begin
            t_new = (t_cur != TURN_MAX) ? t_cur + 16'sd1 : t_cur;
        end else if (dec) begin
            t_new = (t_cur != TURN_MIN) ? t_cur - 16'sd1 : t_cur;
        end else begin
            t_new = t_cur;
        end
    end

    always_comb begin
        n_last  = r_last;
        n_turns = r_turns;
        n_seen  = r_seen;
        n_fail  = r_fail;
        n_div   = r_div;
        bad     = i_cmd.tx_failed || !(&r_seen);
        if (i_cmd.track) begin
            for (int k = 0; k < MOTORS; k++) begin
                n_last[k] = ENC_PARK;
            end
        end
        case (i_cmd.kind)
            KIND_ENC, KIND_TORQUE: begin
                n_last[mi]  = i_cmd.enc;
                n_turns[mi] = t_new;
                n_seen[mi]  = 1'b1;
            end
            KIND_STATUS, KIND_GAINS, KIND_ACK: n_seen[mi] = 1'b1;
            KIND_UNKNOWN: n_seen[mi] = 1'b0;
            KIND_CYCLE: begin
                if (bad) begin
                    n_fail = (r_fail != FAIL_MAX) ? r_fail + 8'd1 : r_fail;
                    n_div  = r_div || (n_fail >= i_cfg.fail_limit);
                end else begin
                    n_fail = '0;
                end
                n_seen = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_a       = '0;
        n_a.kind  = i_cmd.kind;
        n_a.motor = i_cmd.motor[1:0];
        n_a.neg   = i_cmd.neg;
        n_a.enc   = unwrap ? i_cmd.enc : 16'h0;
        n_a.turns = unwrap ? t_new : 16'sh0;
        n_a.trq   = i_cmd.trq;
        n_a.spd   = i_cmd.spd;
        n_a.temp  = i_cmd.temp;
        n_a.volt  = i_cmd.volt;
        n_a.err   = i_cmd.err;
        n_a.fail  = n_fail;
        n_a.div   = n_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTORS; k++) begin
                r_last[k]  <= ENC_PARK;
                r_turns[k] <= '0;
            end
            r_seen    <= '0;
            r_fail    <= '0;
            r_div     <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            if (go) begin
                r_last  <= n_last;
                r_turns <= n_turns;
                r_seen  <= n_seen;
                r_fail  <= n_fail;
                r_div   <= n_div;
            end
            if (en) begin
                r_a_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_a <= n_a;
        end
    end

    // position = enc + 65535 * turns
    logic [31:0] pos;
    logic        trq_kind;

    assign pos = {16'h0, r_a.enc} + {r_a.turns, 16'h0}
               - {{16{r_a.turns[15]}}, r_a.turns};
    assign trq_kind = (r_a.kind == KIND_TORQUE);

    always_comb begin
        o_res                = '0;
        o_res.motor          = r_a.motor;
        o_res.kind           = r_a.kind;
        o_res.position       = r_a.neg ? -$signed(pos) : $signed(pos);
        o_res.torque_current = (r_a.neg && trq_kind) ? neg16(r_a.trq) : $signed(r_a.trq);
        o_res.speed          = (r_a.neg && trq_kind) ? neg16(r_a.spd) : $signed(r_a.spd);
        o_res.temperature    = r_a.temp;
        o_res.voltage        = r_a.volt;
        o_res.fault_code     = r_a.err;
        o_res.fail_count     = r_a.fail;
        o_res.diverged       = r_a.div;
    end

    assign o_res_valid = r_a_valid;

endmodule
`default_nettype wire

>>> rtl/motor_reply_decoder_multiturn.sv
// Path: a pushed event passes the mid queue, the back register and the result queue.
// Throughput: one event per cycle while the result queue has room.
// Reset (i_rst_n low, synchronous): both queues empty, encoder tracking parked,
// turn counts, seen bits, failure count and diverged flag cleared, registers to defaults.
`default_nettype none
module motor_reply_decoder_multiturn #(
    parameter int MOTORS = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire mrd_pkg::t_in                  i_in,
    output logic                               empty,
    input  wire logic                          pop,
    output mrd_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [mrd_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  wire logic [mrd_pkg::CFG_DW-1:0]    i_cfg_data
);
    import mrd_pkg::*;

    t_cfg  r_cfg;
    t_cmd  front_cmd, mid_cmd;
    t_out  back_res;
    logic  mid_empty, mid_pop, res_valid, out_full;
    logic [$bits(t_cmd)-1:0] mid_data;
    logic [$bits(t_out)-1:0] out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_base     <= RST_ID_BASE;
            r_cfg.axis_negate <= RST_AXIS_NEGATE;
            r_cfg.fail_limit  <= RST_FAIL_LIMIT;
            r_cfg.wrap_low    <= RST_WRAP_LOW;
            r_cfg.wrap_high   <= RST_WRAP_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ID_BASE:     r_cfg.id_base     <= i_cfg_data[10:0];
                REG_AXIS_NEGATE: r_cfg.axis_negate <= i_cfg_data[2:0];
                REG_FAIL_LIMIT:  r_cfg.fail_limit  <= i_cfg_data[7:0];
                REG_WRAP_LOW:    r_cfg.wrap_low    <= i_cfg_data;
                REG_WRAP_HIGH:   r_cfg.wrap_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mrd_front #(.MOTORS(MOTORS)) u_front (
        .i_in  (i_in),
        .i_cfg (r_cfg),
        .o_cmd (front_cmd)
    );

    mrd_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign mid_cmd = t_cmd'(mid_data);

    mrd_back #(.MOTORS(MOTORS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (mid_cmd),
        .i_cmd_valid (!mid_empty),
        .o_cmd_pop   (mid_pop),
        .i_res_ready (!out_full),
        .o_res_valid (res_valid),
        .o_res       (back_res)
    );

    mrd_fifo #(.WIDTH($bits(t_out)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_out = t_out'(out_data);

endmodule
`default_nettype wire

>>> rtl/mrd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mrd_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          full,
    input  wire logic          empty,
    input  wire logic          pop,
    input  wire mrd_pkg::t_out o_out
);
    import mrd_pkg::*;

    logic held;
    logic div_out;
    logic frame_free;
    logic motor_clear;

    assign held        = !empty && !pop;
    assign div_out     = !empty && pop && o_out.diverged;
    assign frame_free  = !empty && (o_out.kind == KIND_CYCLE || o_out.kind == KIND_IGNORED);
    assign motor_clear = (o_out.motor == 2'd0) && (o_out.position == 32'sd0);

    `MRD_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (empty && !full), "queues not empty after reset")
    `MRD_ASSERT(a_out_hold, held |=> (!empty && $stable(o_out)), "stalled result changed")
    `MRD_ASSERT(a_div_sticky, div_out |=> (empty || o_out.diverged), "diverged flag dropped")
    `MRD_ASSERT(a_no_motor, frame_free |-> motor_clear, "motor fields on non-frame result")

endmodule

bind motor_reply_decoder_multiturn mrd_checker u_mrd_checker (.*);
`default_nettype wire
